>>> rtl/core/kred_pkg.sv
// Shared types and constants for the keyboard report event differ.
// No dependencies.
package kred_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int SLOT_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int MOD_BITS  = 8;
  localparam int CNT_W     = (SLOT_W > 3) ? SLOT_W : 3;

  localparam logic [7:0] MOD_BASE         = 8'hE0;
  localparam logic [7:0] CODE_NUM_LOCK    = 8'h53;
  localparam logic [7:0] CODE_CAPS_LOCK   = 8'h39;
  localparam logic [7:0] CODE_SCROLL_LOCK = 8'h47;
  localparam logic [2:0] LED_NUM          = 3'b001;
  localparam logic [2:0] LED_CAPS         = 3'b010;
  localparam logic [2:0] LED_SCROLL       = 3'b100;

  typedef logic [7:0] key_t;

  typedef struct packed {
    logic [7:0] modifiers;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } in_t;

  typedef struct packed {
    logic [7:0] event_key;
    logic       pressed;
    logic [2:0] lock_leds;
    logic       leds_changed;
    logic       last_event;
  } out_t;

  // Event as produced by the sequencer, before the last-event mark is known.
  typedef struct packed {
    logic [7:0] event_key;
    logic       pressed;
    logic [2:0] lock_leds;
    logic       leds_changed;
  } evt_t;

  // Handshake between the sequencer and the output stage.
  typedef struct packed {
    logic evt_valid;
    logic flush;
  } evt_ctl_t;

  typedef struct packed {
    logic evt_stall;
    logic flush_done;
  } evt_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REL,
    ST_MODR,
    ST_MODP,
    ST_PRESS,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/kred_match.sv
// Compare unit: one key code against every slot of the current report.
// Depends on kred_pkg.
module kred_match (
  input  kred_pkg::key_t                     key,
  input  kred_pkg::key_t [kred_pkg::KEY_SLOTS-1:0] slots,
  output logic                               hit,
  output logic [kred_pkg::KEY_SLOTS-1:0]     first
);
  import kred_pkg::*;

  logic [KEY_SLOTS-1:0] eq;

  always_comb begin
    first = '0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      eq[j] = (slots[j] == key);
    end
    // Lowest matching slot wins.
    for (int j = KEY_SLOTS - 1; j >= 0; j--) begin
      if (eq[j]) begin
        first = '0;
        first[j] = 1'b1;
      end
    end
    hit = |eq;
  end

endmodule

>>> rtl/core/kred_out.sv
// Output stage: one pending event plus the output register.
// The pending event is marked last when the sequencer flushes. Depends on kred_pkg.
module kred_out (
  input  logic              clk,
  input  logic              rst_n,
  input  kred_pkg::evt_ctl_t ctl,
  input  kred_pkg::evt_t     evt,
  output kred_pkg::evt_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output kred_pkg::out_t     out_data
);
  import kred_pkg::*;

  logic   pend_v_r, pend_v_nxt;
  evt_t   pend_r, pend_nxt;
  logic   out_v_r, out_v_nxt;
  out_t   out_r, out_nxt;
  logic   free;

  always_comb begin
    free       = !out_v_r || out_ready;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && !out_ready;
    out_nxt    = out_r;
    sts.evt_stall  = ctl.evt_valid && pend_v_r && !free;
    sts.flush_done = 1'b0;
    if (ctl.evt_valid && !sts.evt_stall) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = {pend_r, 1'b0};
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = evt;
    end else if (ctl.flush) begin
      if (!pend_v_r) begin
        sts.flush_done = 1'b1;
      end else if (free) begin
        out_v_nxt      = 1'b1;
        out_nxt        = {pend_r, 1'b1};
        pend_v_nxt     = 1'b0;
        sts.flush_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> rtl/core/keyboard_report_event_diff.sv
// Boot keyboard report differ: turns each report into key and modifier events.
// The sequencer takes one step per old slot, per modifier bit (twice: releases, then
// presses), per new slot, plus one closing step that pushes out the last event.
// Output back-pressure holds a step until the output stage can take its event.
// A new report is taken only when the previous one is done: in_ready is high only in ST_IDLE.
// Reset (synchronous, rst_n low) clears the stored report and the lock LED state.
module keyboard_report_event_diff (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kred_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kred_pkg::out_t out_data
);
  import kred_pkg::*;

  // Sequencer state and the step counter shared by all phases.
  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;

  // Stored report from the previous request and the report in work.
  key_t [KEY_SLOTS-1:0]     prev_keys_r, prev_keys_nxt;
  logic [7:0]               prev_mods_r, prev_mods_nxt;
  key_t [KEY_SLOTS-1:0]     cur_keys_r, cur_keys_nxt;
  logic [7:0]               cur_mods_r, cur_mods_nxt;

  // New slots claimed by an old key that is still down.
  logic [KEY_SLOTS-1:0]     held_r, held_nxt;
  logic [2:0]               lock_r, lock_nxt;

  logic [SLOT_W-1:0]        slot;
  logic [2:0]               bitn;
  key_t                     old_key;
  logic                     hit;
  logic [KEY_SLOTS-1:0]     first;
  logic                     last_step;

  evt_ctl_t                 ctl;
  evt_sts_t                 sts;
  evt_t                     evt;
  logic [2:0]               toggle;

  function automatic logic [2:0] lock_toggle(input key_t key);
    logic [2:0] t;
    t = 3'b000;
    if (key == CODE_NUM_LOCK) begin
      t = LED_NUM;
    end else if (key == CODE_CAPS_LOCK) begin
      t = LED_CAPS;
    end else if (key == CODE_SCROLL_LOCK) begin
      t = LED_SCROLL;
    end
    return t;
  endfunction

  assign slot    = idx_r[SLOT_W-1:0];
  assign bitn    = idx_r[2:0];
  assign old_key = prev_keys_r[slot];

  // The shared compare unit looks up one old key per release step.
  kred_match u_match (
    .key   (old_key),
    .slots (cur_keys_r),
    .hit   (hit),
    .first (first)
  );

  kred_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .evt       (evt),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    prev_keys_nxt = prev_keys_r;
    prev_mods_nxt = prev_mods_r;
    cur_keys_nxt  = cur_keys_r;
    cur_mods_nxt  = cur_mods_r;
    held_nxt      = held_r;
    lock_nxt      = lock_r;
    in_ready      = (state_r == ST_IDLE);
    ctl.evt_valid = 1'b0;
    ctl.flush     = 1'b0;
    evt.event_key = old_key;
    evt.pressed   = 1'b0;
    last_step     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cur_mods_nxt    = in_data.modifiers;
          cur_keys_nxt[0] = in_data.key_slot_0;
          cur_keys_nxt[1] = in_data.key_slot_1;
          cur_keys_nxt[2] = in_data.key_slot_2;
          cur_keys_nxt[3] = in_data.key_slot_3;
          cur_keys_nxt[4] = in_data.key_slot_4;
          cur_keys_nxt[5] = in_data.key_slot_5;
          held_nxt        = '0;
          idx_nxt         = '0;
          state_nxt       = ST_REL;
        end
      end
      ST_REL: begin
        // An old key found in the new report marks its first slot as held;
        // otherwise it is released.
        last_step = (idx_r == CNT_W'(KEY_SLOTS - 1));
        if (old_key != '0) begin
          if (hit) begin
            held_nxt = held_r | first;
          end else begin
            ctl.evt_valid = 1'b1;
          end
        end
      end
      ST_MODR: begin
        last_step     = (bitn == 3'(MOD_BITS - 1));
        evt.event_key = MOD_BASE + 8'(bitn);
        ctl.evt_valid = prev_mods_r[bitn] && !cur_mods_r[bitn];
      end
      ST_MODP: begin
        last_step     = (bitn == 3'(MOD_BITS - 1));
        evt.event_key = MOD_BASE + 8'(bitn);
        evt.pressed   = 1'b1;
        ctl.evt_valid = !prev_mods_r[bitn] && cur_mods_r[bitn];
      end
      ST_PRESS: begin
        last_step     = (idx_r == CNT_W'(KEY_SLOTS - 1));
        evt.event_key = cur_keys_r[slot];
        evt.pressed   = 1'b1;
        ctl.evt_valid = !held_r[slot] && (cur_keys_r[slot] != '0);
      end
      ST_DONE: begin
        // Push out the final event with its last mark, then keep the report.
        ctl.flush = 1'b1;
        if (sts.flush_done) begin
          prev_keys_nxt = cur_keys_r;
          prev_mods_nxt = cur_mods_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Only presses toggle a lock LED.
    toggle           = evt.pressed ? lock_toggle(evt.event_key) : 3'b000;
    evt.lock_leds    = lock_r ^ toggle;
    evt.leds_changed = |toggle;

    // A step advances unless its event has to wait for the output stage.
    if (state_r == ST_REL || state_r == ST_MODR || state_r == ST_MODP ||
        state_r == ST_PRESS) begin
      if (!(ctl.evt_valid && sts.evt_stall)) begin
        if (ctl.evt_valid) begin
          lock_nxt = evt.lock_leds;
        end
        if (last_step) begin
          idx_nxt = '0;
          case (state_r)
            ST_REL:   state_nxt = ST_MODR;
            ST_MODR:  state_nxt = ST_MODP;
            ST_MODP:  state_nxt = ST_PRESS;
            default:  state_nxt = ST_DONE;
          endcase
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      held_r      <= '0;
      lock_r      <= '0;
      prev_keys_r <= '0;
      prev_mods_r <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      held_r      <= held_nxt;
      lock_r      <= lock_nxt;
      prev_keys_r <= prev_keys_nxt;
      prev_mods_r <= prev_mods_nxt;
    end
    cur_keys_r <= cur_keys_nxt;
    cur_mods_r <= cur_mods_nxt;
  end

endmodule
